// ===== design/i2cm_pkg.sv =====
// Package for the I2C master bit engine.
// It holds the command codes, the reset values of the configuration registers and the result type.
// No dependencies.
package i2cm_pkg;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_WAIT    = 3'd4,
    OP_RD_ACK  = 3'd5,
    OP_RD_NACK = 3'd6,
    OP_RSVD    = 3'd7
  } op_t;

  typedef enum logic {
    REG_ACK_TIMEOUT    = 1'b0,
    REG_TICKS_PER_UNIT = 1'b1
  } reg_idx_t;

  localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;
  localparam logic [7:0] TICKS_PER_UNIT_RST = 8'd1;
  localparam logic [7:0] MSB_MASK           = 8'h80;

  typedef struct packed {
    logic       ack_error;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_enable;
    logic       sda_drive;
    logic       scl_level;
  } res_t;

endpackage

// ===== design/i2cm_seq.sv =====
// Sequencer for the I2C master bit engine: pin sequences, bit and unit counting, ack polling.
// It holds the engine state and gives the result of the current tick combinationally.
// Depends on i2cm_pkg.
module i2cm_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic [2:0]     opcode,
  input  logic [7:0]     tx_byte,
  input  logic           sda_level,
  input  logic [7:0]     ack_timeout,
  input  logic [7:0]     ticks_per_unit,
  output i2cm_pkg::res_t res
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_SP_A    = 4'd3,
    PH_SP_B    = 4'd4,
    PH_SP_C    = 4'd5,
    PH_WR_LOW  = 4'd6,
    PH_WR_DATA = 4'd7,
    PH_WR_HIGH = 4'd8,
    PH_WA_LOW  = 4'd9,
    PH_WA_HIGH = 4'd10,
    PH_WA_POLL = 4'd11,
    PH_RD_LOW  = 4'd12,
    PH_RD_HIGH = 4'd13,
    PH_AK_A    = 4'd14,
    PH_AK_B    = 4'd15
  } phase_t;

  phase_t           phase_r, phase_nxt, ent_ph;
  i2cm_pkg::op_t    cmd_r, cmd_nxt, op;
  logic [3:0]       bit_cnt_r, bit_cnt_nxt, bit_inc;
  logic [1:0]       unit_cnt_r, unit_cnt_nxt, unit_dec, units;
  logic [7:0]       presc_r, presc_nxt, presc_inc;
  logic [7:0]       shift_r, shift_nxt;
  logic [7:0]       tmo_r, tmo_nxt;
  logic             scl_r, scl_nxt, sda_r, sda_nxt, en_r, en_nxt;
  logic             err_r, err_nxt;
  logic [7:0]       rx_r, rx_nxt;
  logic             done, do_ent, do_cmpl;

  assign op = i2cm_pkg::op_t'(opcode);

  always_comb begin
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    bit_cnt_nxt  = bit_cnt_r;
    unit_cnt_nxt = unit_cnt_r;
    presc_nxt    = presc_r;
    shift_nxt    = shift_r;
    tmo_nxt      = tmo_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    en_nxt       = en_r;
    err_nxt      = err_r;
    rx_nxt       = rx_r;
    done         = 1'b0;
    do_ent       = 1'b0;
    do_cmpl      = 1'b0;
    ent_ph       = PH_IDLE;
    units        = 2'd0;
    bit_inc      = bit_cnt_r + 4'd1;
    presc_inc    = presc_r + 8'd1;
    unit_dec     = (unit_cnt_r != 2'd0) ? unit_cnt_r - 2'd1 : unit_cnt_r;

    if (phase_r == PH_IDLE) begin
      if (op != i2cm_pkg::OP_NONE && op != i2cm_pkg::OP_RSVD) begin
        cmd_nxt     = op;
        bit_cnt_nxt = 4'd0;
        do_ent      = 1'b1;
        unique case (op)
          i2cm_pkg::OP_START: ent_ph = PH_ST_A;
          i2cm_pkg::OP_STOP:  ent_ph = PH_SP_A;
          i2cm_pkg::OP_WRITE: begin
            shift_nxt = tx_byte;
            ent_ph    = PH_WR_LOW;
          end
          i2cm_pkg::OP_WAIT: begin
            err_nxt = 1'b0;
            tmo_nxt = 8'd0;
            ent_ph  = PH_WA_LOW;
          end
          default: begin
            shift_nxt = 8'd0;
            ent_ph    = PH_RD_LOW;
          end
        endcase
      end
    end else if (phase_r == PH_WA_POLL) begin
      if (!sda_level) begin
        scl_nxt = 1'b0;
        do_cmpl = 1'b1;
      end else if (tmo_r >= ack_timeout) begin
        err_nxt = 1'b1;
        do_ent  = 1'b1;
        ent_ph  = PH_SP_A;
      end else begin
        tmo_nxt = tmo_r + 8'd1;
      end
    end else if (presc_inc >= ticks_per_unit) begin
      presc_nxt    = 8'd0;
      unit_cnt_nxt = unit_dec;
      if (unit_dec == 2'd0) begin
        unique case (phase_r)
          PH_ST_A: begin
            do_ent = 1'b1;
            ent_ph = PH_ST_B;
          end
          PH_ST_B: begin
            scl_nxt = 1'b0;
            do_cmpl = 1'b1;
          end
          PH_SP_A: begin
            do_ent = 1'b1;
            ent_ph = PH_SP_B;
          end
          PH_SP_B: begin
            do_ent = 1'b1;
            ent_ph = PH_SP_C;
          end
          PH_WR_LOW: begin
            do_ent = 1'b1;
            ent_ph = PH_WR_DATA;
          end
          PH_WR_DATA: begin
            do_ent = 1'b1;
            ent_ph = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            bit_cnt_nxt = bit_inc;
            if (bit_inc < 4'd8) begin
              do_ent = 1'b1;
              ent_ph = PH_WR_LOW;
            end else begin
              scl_nxt = 1'b0;
              do_cmpl = 1'b1;
            end
          end
          PH_WA_LOW: begin
            do_ent = 1'b1;
            ent_ph = PH_WA_HIGH;
          end
          PH_WA_HIGH: begin
            phase_nxt    = PH_WA_POLL;
            unit_cnt_nxt = 2'd0;
          end
          PH_RD_LOW: begin
            do_ent = 1'b1;
            ent_ph = PH_RD_HIGH;
          end
          PH_RD_HIGH: begin
            shift_nxt   = {shift_r[6:0], sda_level};
            bit_cnt_nxt = bit_inc;
            do_ent      = 1'b1;
            if (bit_inc < 4'd8) begin
              ent_ph = PH_RD_LOW;
            end else begin
              rx_nxt = {shift_r[6:0], sda_level};
              ent_ph = PH_AK_A;
            end
          end
          PH_AK_A: begin
            do_ent = 1'b1;
            ent_ph = PH_AK_B;
          end
          PH_AK_B: begin
            scl_nxt = 1'b0;
            do_cmpl = 1'b1;
          end
          default: do_cmpl = 1'b1;
        endcase
      end
    end else begin
      presc_nxt = presc_inc;
    end

    if (do_ent) begin
      unique case (ent_ph)
        PH_ST_A: begin
          en_nxt  = 1'b1;
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
          units   = 2'd2;
        end
        PH_ST_B: begin
          sda_nxt = 1'b0;
          units   = 2'd2;
        end
        PH_SP_A: begin
          en_nxt  = 1'b1;
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
          units   = 2'd2;
        end
        PH_SP_B: begin
          scl_nxt = 1'b1;
          units   = 2'd1;
        end
        PH_SP_C: begin
          sda_nxt = 1'b1;
          units   = 2'd2;
        end
        PH_WR_LOW: begin
          en_nxt  = 1'b1;
          scl_nxt = 1'b0;
          units   = 2'd1;
        end
        PH_WR_DATA: begin
          sda_nxt   = (shift_nxt & i2cm_pkg::MSB_MASK) != 8'd0;
          shift_nxt = {shift_nxt[6:0], 1'b0};
          units     = 2'd1;
        end
        PH_WR_HIGH: begin
          scl_nxt = 1'b1;
          units   = 2'd2;
        end
        PH_WA_LOW: begin
          en_nxt  = 1'b0;
          scl_nxt = 1'b0;
          units   = 2'd1;
        end
        PH_WA_HIGH: begin
          scl_nxt = 1'b1;
          units   = 2'd1;
        end
        PH_RD_LOW: begin
          en_nxt  = 1'b0;
          scl_nxt = 1'b0;
          units   = 2'd2;
        end
        PH_RD_HIGH: begin
          scl_nxt = 1'b1;
          units   = 2'd2;
        end
        PH_AK_A: begin
          scl_nxt = 1'b0;
          en_nxt  = 1'b1;
          sda_nxt = (cmd_nxt != i2cm_pkg::OP_RD_ACK);
          units   = 2'd2;
        end
        PH_AK_B: begin
          scl_nxt = 1'b1;
          units   = 2'd2;
        end
        default: units = 2'd0;
      endcase
      phase_nxt    = ent_ph;
      unit_cnt_nxt = units;
      presc_nxt    = 8'd0;
    end

    if (do_cmpl) begin
      phase_nxt    = PH_IDLE;
      unit_cnt_nxt = 2'd0;
      presc_nxt    = 8'd0;
      done         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cmd_r      <= i2cm_pkg::OP_NONE;
      bit_cnt_r  <= 4'd0;
      unit_cnt_r <= 2'd0;
      presc_r    <= 8'd0;
      shift_r    <= 8'd0;
      tmo_r      <= 8'd0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      en_r       <= 1'b1;
      err_r      <= 1'b0;
      rx_r       <= 8'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      cmd_r      <= cmd_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      unit_cnt_r <= unit_cnt_nxt;
      presc_r    <= presc_nxt;
      shift_r    <= shift_nxt;
      tmo_r      <= tmo_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      en_r       <= en_nxt;
      err_r      <= err_nxt;
      rx_r       <= rx_nxt;
    end
  end

  always_comb begin
    res.scl_level  = scl_nxt;
    res.sda_drive  = sda_nxt;
    res.sda_enable = en_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_nxt;
    res.ack_error  = err_nxt;
  end

endmodule

// ===== design/i2cm_out_reg.sv =====
// Output register stage for the I2C master bit engine.
// It holds one result and gives back pressure to the input side.
// Depends on i2cm_pkg.
module i2cm_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  i2cm_pkg::res_t res_in,
  input  logic           out_tready,
  output logic           out_tvalid,
  output i2cm_pkg::res_t res_out,
  output logic           space
);

  logic           valid_r;
  i2cm_pkg::res_t data_r;

  assign space      = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign res_out    = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

endmodule

// ===== design/i2c_master_bit_engine_top.sv =====
// The result of a tick is registered on its input transfer and presented from the output register.
// Throughput: one tick per clock while the result side takes each result.
// Back pressure on the result side stalls the input through the output register.
// Reset (rst_n, synchronous, active low): engine idle, SCL and SDA high and driven,
// counters, received byte and error flag cleared, ack_timeout 250, ticks_per_unit 1.
module i2c_master_bit_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tx_byte[7:0], sda_level[8], zero fill
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_level, sda_drive, sda_enable, busy_res,
                                  // done_res, rx_byte[12:5], ack_error[13], zero fill
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]     ack_timeout_r;
  logic [7:0]     ticks_per_unit_r;
  logic           step_en;
  i2cm_pkg::res_t res_c, res_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r    <= i2cm_pkg::ACK_TIMEOUT_RST;
      ticks_per_unit_r <= i2cm_pkg::TICKS_PER_UNIT_RST;
    end else if (cfg_we) begin
      if (i2cm_pkg::reg_idx_t'(cfg_index) == i2cm_pkg::REG_ACK_TIMEOUT) begin
        ack_timeout_r <= cfg_wdata;
      end else begin
        ticks_per_unit_r <= cfg_wdata;
      end
    end
  end

  assign step_en = in_tvalid && in_tready;

  i2cm_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .opcode         (in_tuser),
    .tx_byte        (in_tdata[7:0]),
    .sda_level      (in_tdata[8]),
    .ack_timeout    (ack_timeout_r),
    .ticks_per_unit (ticks_per_unit_r),
    .res            (res_c)
  );

  i2cm_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step_en),
    .res_in     (res_c),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_out    (res_q),
    .space      (in_tready)
  );

  assign out_tdata = {2'b00, res_q};

endmodule

// ===== design/i2cm_checker.sv =====
// Port checker for the I2C master bit engine, bound to the top level.
// Depends on the top level's ports only.
module i2cm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or dropped.");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("Input stalled while the result register is empty.");

  a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("Input transfer produced no result.");

  a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[3])
    else $error("Completion shown while still busy.");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
